@@ hdl/mhre_pkg.sv @@
package mhre_pkg;

  // register file geometry and request limits
  localparam int REG_COUNT      = 256;
  localparam int MAX_READ_REGS  = 31;
  localparam int WRITE_MAX_REGS = 123;
  localparam int ADDR_W         = $clog2(REG_COUNT);
  localparam int WIDX_W         = $clog2(WRITE_MAX_REGS + 1);
  localparam int REM_W          = $clog2(MAX_READ_REGS + 1);
  localparam int POS_W          = 9;

  // command queue depth, a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CMD_ERR   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_ECHO  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic       mode;
    logic       first;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [1:0]        status;
    logic [15:0]       addr;
    logic [15:0]       count;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              echo;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

@@ hdl/mhre_ram.sv @@
module mhre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/mhre_front.sv @@
module mhre_front import mhre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t item,
  output logic     push,
  output cmd_t     cmd
);

  localparam logic [POS_W-1:0] POS_ADDR_HI  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ADDR_LO  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CNT_HI   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CNT_LO   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_BYTE_CNT = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DATA     = POS_W'(5);
  localparam logic [POS_W-1:0] POS_IDLE     = POS_W'(511);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(510);
  localparam logic [16:0]      REG_SPAN     = 17'(REG_COUNT);
  localparam logic [15:0]      RD_LIMIT     = 16'(MAX_READ_REGS);
  localparam logic [15:0]      WR_LIMIT     = 16'(WRITE_MAX_REGS);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic              mode_r, mode_nxt, mode_eff;
  logic [15:0]       addr_r, addr_nxt;
  logic [15:0]       cnt_r, cnt_nxt, cnt_full, limit;
  logic [WIDX_W-1:0] widx_r, widx_nxt, widx_eff;
  logic [7:0]        hold_r, hold_nxt;
  logic [16:0]       span;
  logic [WIDX_W:0]   stored;

  always_comb begin
    pos_eff  = item.first ? '0 : pos_r;
    mode_eff = item.first ? item.mode : mode_r;
    widx_eff = item.first ? '0 : widx_r;
    cnt_full = {cnt_r[15:8], item.data_byte};
    limit    = mode_eff ? WR_LIMIT : RD_LIMIT;
    span     = {1'b0, addr_r} + {1'b0, cnt_full};
    stored   = {1'b0, widx_eff} + 1'b1;

    pos_nxt  = pos_r;
    mode_nxt = mode_r;
    addr_nxt = addr_r;
    cnt_nxt  = cnt_r;
    widx_nxt = widx_r;
    hold_nxt = hold_r;

    push       = 1'b0;
    cmd        = '0;
    cmd.kind   = CMD_ECHO;
    cmd.status = ST_OK;
    cmd.addr   = addr_r;
    cmd.count  = cnt_r;
    cmd.waddr  = addr_r[ADDR_W-1:0] + ADDR_W'(widx_eff);
    cmd.wdata  = {hold_r, item.data_byte};

    if (acc) begin
      mode_nxt = mode_eff;
      widx_nxt = widx_eff;
      pos_nxt  = pos_eff;
      case (pos_eff)
        POS_ADDR_HI: begin
          addr_nxt = {item.data_byte, 8'h00};
          pos_nxt  = POS_ADDR_LO;
        end
        POS_ADDR_LO: begin
          addr_nxt = {addr_r[15:8], item.data_byte};
          pos_nxt  = POS_CNT_HI;
        end
        POS_CNT_HI: begin
          cnt_nxt = {item.data_byte, 8'h00};
          pos_nxt = POS_CNT_LO;
        end
        POS_CNT_LO: begin
          cnt_nxt   = cnt_full;
          cmd.count = cnt_full;
          if (cnt_full > limit) begin
            push       = 1'b1;
            cmd.kind   = CMD_ERR;
            cmd.status = ST_COUNT;
            pos_nxt    = POS_IDLE;
          end else if (span > REG_SPAN) begin
            push       = 1'b1;
            cmd.kind   = CMD_ERR;
            cmd.status = ST_RANGE;
            pos_nxt    = POS_IDLE;
          end else if (!mode_eff) begin
            push     = 1'b1;
            cmd.kind = CMD_READ;
            pos_nxt  = POS_IDLE;
          end else begin
            widx_nxt = '0;
            pos_nxt  = POS_BYTE_CNT;
          end
        end
        POS_BYTE_CNT: begin
          // byte count field carries nothing the counts do not
          if (cnt_r == '0) begin
            push     = 1'b1;
            cmd.kind = CMD_ECHO;
            pos_nxt  = POS_IDLE;
          end else begin
            pos_nxt = POS_DATA;
          end
        end
        default: begin
          if (pos_eff inside {[POS_DATA:POS_LAST]}) begin
            if (pos_eff[0]) begin
              hold_nxt = item.data_byte;
              pos_nxt  = pos_eff + 1'b1;
            end else begin
              push     = 1'b1;
              cmd.kind = CMD_WRITE;
              cmd.echo = (stored >= {1'b0, cnt_r[WIDX_W-1:0]});
              widx_nxt = stored[WIDX_W-1:0];
              pos_nxt  = cmd.echo ? POS_IDLE : pos_eff + 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= 1'b0;
      addr_r <= '0;
      cnt_r  <= '0;
      widx_r <= '0;
      hold_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      addr_r <= addr_nxt;
      cnt_r  <= cnt_nxt;
      widx_r <= widx_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

@@ hdl/mhre_queue.sv @@
module mhre_queue import mhre_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_data,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign stat.not_empty = (cnt_r != '0);
  assign stat.full      = (cnt_r == QCNT_W'(QDEPTH));
  assign head           = q_r[rd_ptr_r];
  assign do_pop         = pop && stat.not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("command pushed into a full queue");
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.not_empty)
    else $error("command popped from an empty queue");
`endif

endmodule

@@ hdl/mhre_back.sv @@
module mhre_back import mhre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_stat_t   qstat,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_ECHO = 3'b100
  } bstate_t;

  bstate_t           st_r, st_nxt;
  logic              half_r, half_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0] next_r, next_nxt;
  logic [1:0]        ek_r, ek_nxt;
  logic [15:0]       eaddr_r, eaddr_nxt;
  logic [15:0]       ecnt_r, ecnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [REG_COUNT-1:0] vld_r;
  logic              rd_vld_r;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       rd_data, rd_word;
  logic [7:0]        echo_byte;

  mhre_ram #(
    .WIDTH(16),
    .DEPTH(REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(head.waddr),
    .wr_data(head.wdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // never-written entries read as zero
  assign rd_word = rd_vld_r ? rd_data : '0;

  always_comb begin
    case (ek_r)
      2'd0:    echo_byte = eaddr_r[15:8];
      2'd1:    echo_byte = eaddr_r[7:0];
      2'd2:    echo_byte = ecnt_r[15:8];
      default: echo_byte = ecnt_r[7:0];
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    half_nxt      = half_r;
    rem_nxt       = rem_r;
    next_nxt      = next_r;
    ek_nxt        = ek_r;
    eaddr_nxt     = eaddr_r;
    ecnt_nxt      = ecnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = next_r;

    case (st_r)
      B_IDLE: begin
        if (qstat.not_empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_ERR: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{resp_byte: 8'h00, last: 1'b1, status: head.status};
            end
            CMD_READ: begin
              // count is at most 31 here, so twice it fits a byte
              out_valid_nxt = 1'b1;
              out_nxt       = '{resp_byte: {head.count[6:0], 1'b0},
                                last: (head.count == '0), status: ST_OK};
              if (head.count != '0) begin
                rd_en    = 1'b1;
                rd_addr  = head.addr[ADDR_W-1:0];
                next_nxt = head.addr[ADDR_W-1:0] + 1'b1;
                rem_nxt  = head.count[REM_W-1:0];
                half_nxt = 1'b0;
                st_nxt   = B_READ;
              end
            end
            CMD_WRITE: begin
              wr_en = 1'b1;
              if (head.echo) begin
                eaddr_nxt = head.addr;
                ecnt_nxt  = head.count;
                ek_nxt    = '0;
                st_nxt    = B_ECHO;
              end
            end
            CMD_ECHO: begin
              eaddr_nxt = head.addr;
              ecnt_nxt  = head.count;
              ek_nxt    = '0;
              st_nxt    = B_ECHO;
            end
            default: begin
              st_nxt = B_IDLE;
            end
          endcase
        end
      end
      B_READ: begin
        out_valid_nxt = 1'b1;
        if (!half_r) begin
          out_nxt  = '{resp_byte: rd_word[15:8], last: 1'b0, status: ST_OK};
          half_nxt = 1'b1;
        end else begin
          out_nxt  = '{resp_byte: rd_word[7:0], last: (rem_r == REM_W'(1)), status: ST_OK};
          rem_nxt  = rem_r - 1'b1;
          half_nxt = 1'b0;
          if (rem_r == REM_W'(1)) begin
            st_nxt = B_IDLE;
          end else begin
            rd_en    = 1'b1;
            next_nxt = next_r + 1'b1;
          end
        end
      end
      B_ECHO: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{resp_byte: echo_byte, last: (ek_r == 2'd3), status: ST_OK};
        ek_nxt        = ek_r + 1'b1;
        if (ek_r == 2'd3) begin
          st_nxt = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    half_r    <= half_nxt;
    rem_r     <= rem_nxt;
    next_r    <= next_nxt;
    ek_r      <= ek_nxt;
    eaddr_r   <= eaddr_nxt;
    ecnt_r    <= ecnt_nxt;
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r[head.waddr] <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> out_r.last)
    else $error("error response not marked as final byte");
  a_read_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_READ) |-> (rem_r != '0))
    else $error("read burst running with nothing left");
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("register file read and written in one cycle");
`endif

endmodule

@@ hdl/modbus_holding_register_engine_top.sv @@
// a result is registered in the command queue, then in the back end's output register, before it strobes
// throughput: one request byte per cycle until the two-entry command queue fills
// a read of n registers streams 2n+1 bytes on consecutive cycles, an echo 4
// reset (rst_n low, synchronous) clears the parser, queue and back end, and
// marks every register as unwritten so that it reads back as zero
module modbus_holding_register_engine_top import mhre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  // transfer of a request byte
  logic    acc;
  // front to queue
  logic    push;
  cmd_t    push_cmd;
  // queue to back end
  logic    pop;
  cmd_t    head;
  q_stat_t qstat;

  // busy only while the command queue is full: the back end may still be
  // streaming a read burst while the parser takes further bytes
  assign busy = qstat.full;
  assign acc  = start && !busy;

  // front: byte parser, range check, turns each byte into at most one command
  mhre_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .item (in_item),
    .push (push),
    .cmd  (push_cmd)
  );

  // short command queue decouples parsing from response generation
  mhre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  // back end: register file, write commit, read bursts, echo and error bytes;
  // each response byte is flagged by out_valid high for one cycle
  mhre_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .out_valid(out_strobe),
    .out_data (out_item)
  );

endmodule
